// ----- sv/sorted_priority_table_insert_defines.svh -----
// assertion macros shared by the sorted priority table
`ifndef SORTED_PRIORITY_TABLE_INSERT_DEFINES_SVH
`define SORTED_PRIORITY_TABLE_INSERT_DEFINES_SVH

// condition and consequence in the same cycle
`define SPTI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define SPTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/spti_pkg.sv -----
// types and codes of the sorted priority table
`default_nettype none

package spti_pkg;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DUMP   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_DUMPED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		op_t                op;
		logic [7:0]         data_byte;
		logic signed [15:0] priority_req;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [7:0]         out_data;
		logic signed [15:0] out_priority;
		logic [4:0]         occupancy;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic [7:0]         data;
		logic signed [15:0] prio;
	} entry_t;

	typedef struct packed {
		logic       load_carry;
		logic       walk_en;
		logic       place_en;
		logic       out_load;
		status_t    out_status;
		logic       out_last;
		logic [4:0] occupancy;
	} cmd_t;

endpackage

`default_nettype wire

// ----- sv/spti_if.sv -----
// request and result channel interfaces
`default_nettype none

interface spti_req_if;
	import spti_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface spti_rsp_if;
	import spti_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/spti_dp.sv -----
// datapath: entry memory, carried entry and result register
`default_nettype none

module spti_dp #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  spti_pkg::cmd_t  cmd,
	input  logic [AW-1:0]   rd_addr,
	input  logic [AW-1:0]   wr_addr,
	input  spti_pkg::req_t  req_payload,
	input  logic            rsp_ready,
	output logic            rsp_valid,
	output spti_pkg::rsp_t  rsp_payload,
	output logic            out_free
);
	import spti_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;
	entry_t carry_q;
	logic   out_valid_q;
	rsp_t   out_q;
	logic   swap;

	// stored entry sorts after the carry: exchange them
	assign swap = rdata_q.prio > carry_q.prio;

	always_ff @(posedge clk) begin
		if (cmd.place_en || (cmd.walk_en && swap)) begin
			mem_q[wr_addr] <= carry_q;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_carry) begin
			carry_q.data <= req_payload.data_byte;
			carry_q.prio <= req_payload.priority_req;
		end else if (cmd.walk_en && swap) begin
			carry_q <= rdata_q;
		end
	end

	assign out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status    <= cmd.out_status;
			out_q.occupancy <= cmd.occupancy;
			out_q.last      <= cmd.out_last;
			if (cmd.out_status == ST_DUMPED) begin
				out_q.out_data     <= rdata_q.data;
				out_q.out_priority <= rdata_q.prio;
			end else begin
				out_q.out_data     <= '0;
				out_q.out_priority <= '0;
			end
		end
	end

	assign rsp_valid   = out_valid_q;
	assign rsp_payload = out_q;

endmodule

`default_nettype wire

// ----- sv/spti_ctrl.sv -----
// controller: walk, place, emit and dump sequencing
`default_nettype none

module spti_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int CW    = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  spti_pkg::op_t   req_op,
	output logic            req_ready,
	input  logic            out_free,
	output spti_pkg::cmd_t  cmd,
	output logic [AW-1:0]   rd_addr,
	output logic [AW-1:0]   wr_addr,
	output logic [CW-1:0]   count
);
	import spti_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_PLACE,
		S_EMIT,
		S_DUMP
	} state_t;

	state_t        state_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] count_q;
	status_t       emit_status_q;
	logic          accept;
	logic          is_last;

	assign accept  = (state_q == S_IDLE) && req_valid;
	assign is_last = (CW'(idx_q) + CW'(1)) == count_q;

	always_comb begin
		cmd            = '0;
		cmd.load_carry = accept;
		cmd.occupancy  = 5'(count_q);
		cmd.out_status = emit_status_q;
		rd_addr        = idx_q;
		wr_addr        = idx_q;
		case (state_q)
			S_IDLE: begin
				rd_addr = '0;
			end
			S_WALK: begin
				cmd.walk_en = 1'b1;
				rd_addr     = idx_q + AW'(1);
			end
			S_PLACE: begin
				cmd.place_en = 1'b1;
				wr_addr      = count_q[AW-1:0];
			end
			S_EMIT: begin
				cmd.out_load = out_free;
				cmd.out_last = 1'b1;
			end
			S_DUMP: begin
				cmd.out_load   = out_free;
				cmd.out_status = ST_DUMPED;
				cmd.out_last   = is_last;
				rd_addr        = out_free ? idx_q + AW'(1) : idx_q;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			idx_q         <= '0;
			count_q       <= '0;
			emit_status_q <= ST_INSERTED;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						idx_q <= '0;
						if (req_op == OP_INSERT) begin
							if (count_q == CW'(DEPTH)) begin
								emit_status_q <= ST_FULL;
								state_q       <= S_EMIT;
							end else if (count_q == '0) begin
								state_q <= S_PLACE;
							end else begin
								state_q <= S_WALK;
							end
						end else if (count_q == '0) begin
							emit_status_q <= ST_EMPTY;
							state_q       <= S_EMIT;
						end else begin
							state_q <= S_DUMP;
						end
					end
				end
				S_WALK: begin
					if (is_last) begin
						state_q <= S_PLACE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_PLACE: begin
					count_q       <= count_q + CW'(1);
					emit_status_q <= ST_INSERTED;
					state_q       <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DUMP: begin
					if (out_free) begin
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/sorted_priority_table_insert.sv -----
// top level of the sorted priority table
// channels: req (sink) carries an op, a data byte and a signed priority;
//   rsp (source) carries status, dumped data and priority, occupancy, last
// insert: the new entry walks the stored entries front to back, one per
//   cycle, swapping with each entry of strictly greater priority, and the
//   final carry lands at the end; the walk reads through the single read port
// dump: one result per cycle while rsp is ready, last one marked; an
//   empty table gives one empty status
// insert into a full table is dropped with a full status
// one request is in work at a time; req is ready again once its last
//   result sits in the output register, even while rsp is stalled
// a stall on rsp holds the output register and pauses the dump walk
// reset clears the entry count and all control; memory is not cleared,
//   only entries below the count are ever used
`default_nettype none

`include "sorted_priority_table_insert_defines.svh"

module sorted_priority_table_insert #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	spti_req_if.sink   req,
	spti_rsp_if.source rsp
);
	import spti_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          cmd;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] count;
	logic          out_free;
	logic          full_insert;
	logic [CW-1:0] count_p1;
	logic          mem_wr;

	// sequencing of walk, place, emit and dump
	spti_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.payload.op),
		.req_ready (req.ready),
		.out_free  (out_free),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.count     (count)
	);

	// entry memory, compare and swap, result register
	spti_dp #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.req_payload (req.payload),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.rsp_payload (rsp.payload),
		.out_free    (out_free)
	);

	// insert request taken while the table is full
	assign full_insert = req.valid && req.ready && (req.payload.op == OP_INSERT)
		&& (count == CW'(DEPTH));
	assign count_p1    = count + CW'(1);
	assign mem_wr      = cmd.walk_en || cmd.place_en;

	// entry count stays within the table
	`SPTI_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count <= CW'(DEPTH), "count above depth")

	// a dropped insert leaves the entry count as it was
	`SPTI_ASSERT_NEXT(a_full_drop, clk, arst_n, full_insert, $stable(count), "full insert moved count")

	// the count only ever grows by one entry
	`SPTI_ASSERT_SAME(a_count_step, clk, arst_n, $changed(count), count == $past(count_p1), "count jumped")

	// no memory write while a new request can be taken
	`SPTI_ASSERT_SAME(a_idle_quiet, clk, arst_n, req.ready, !mem_wr, "write while idle")

endmodule

`default_nettype wire

// ----- bench/tb_sorted_priority_table_insert.sv -----
// self-checking testbench of the sorted priority table: directed and random requests
module tb_sorted_priority_table_insert;
	timeunit 1ns;
	timeprecision 1ps;

	import spti_pkg::*;

	localparam int DEPTH = 16;
	// limit on the whole run in ns, before the hard stop fires
	localparam int unsigned RUN_LIMIT_NS = 5_000_000;
	// quiet wait after the final drain, longer than the longest insert walk
	localparam int unsigned SETTLE_CYCLES = 40;

	logic clk;
	logic arst_n;

	spti_req_if req_ch ();
	spti_rsp_if rsp_ch ();

	sorted_priority_table_insert #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// shadow of the table as it should look after every accepted request
	logic [7:0]         stored_data [DEPTH];
	logic signed [15:0] stored_prio [DEPTH];
	int                 stored_count;

	// results still owed by the block, oldest first
	rsp_t pending_results[$];

	int mismatch_count;
	int result_count;
	// set for the closing stretch: no gaps on the request side, no stalls on rsp
	bit steady_phase;

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one line per mismatch, counted
	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// apply one accepted request to the shadow table and queue the results it owes
	task automatic predict_table_step(input req_t r);
		logic [7:0]         carry_d;
		logic [7:0]         swap_d;
		logic signed [15:0] carry_p;
		logic signed [15:0] swap_p;
		rsp_t               res;
		res = '0;
		res.last = 1'b1;
		if (r.op == OP_INSERT) begin
			if (stored_count >= DEPTH) begin
				// full table: entry dropped, table untouched
				res.status = ST_FULL;
				res.occupancy = 5'(stored_count);
				pending_results.push_back(res);
			end else begin
				// carry walks front to back, swapping past every strictly larger priority
				carry_d = r.data_byte;
				carry_p = r.priority_req;
				for (int i = 0; i < stored_count; i++) begin
					if (stored_prio[i] > carry_p) begin
						swap_d = stored_data[i];
						swap_p = stored_prio[i];
						stored_data[i] = carry_d;
						stored_prio[i] = carry_p;
						carry_d = swap_d;
						carry_p = swap_p;
					end
				end
				stored_data[stored_count] = carry_d;
				stored_prio[stored_count] = carry_p;
				stored_count++;
				res.status = ST_INSERTED;
				res.occupancy = 5'(stored_count);
				pending_results.push_back(res);
			end
		end else if (stored_count == 0) begin
			res.status = ST_EMPTY;
			pending_results.push_back(res);
		end else begin
			// dump streams every entry in order, last flag on the final one
			for (int i = 0; i < stored_count; i++) begin
				res.status = ST_DUMPED;
				res.out_data = stored_data[i];
				res.out_priority = stored_prio[i];
				res.occupancy = 5'(stored_count);
				res.last = (i == stored_count - 1);
				pending_results.push_back(res);
			end
		end
	endtask

	// present one request and hold it until accepted; valid stays high afterwards
	// so back-to-back requests never drop and raise valid in the same step
	task automatic send_request(input op_t op, input logic [7:0] data_byte,
			input logic signed [15:0] prio);
		req_t        r;
		int unsigned gap;
		r.op = op;
		r.data_byte = data_byte;
		r.priority_req = prio;
		if (!steady_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predict_table_step(r);
	endtask

	// hold off new requests until every owed result has been taken
	task automatic wait_for_results;
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// mix of tie runs, extremes and anything in the range
	function automatic logic signed [15:0] pick_priority();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 4)) - 16'sd2;
			1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: return 16'($urandom());
		endcase
	endfunction

	// dump before anything was stored gives the empty status
	task automatic test_empty_dump;
		send_request(OP_DUMP, 8'h00, 16'sd0);
	endtask

	// extremes of priority and a run of three equal priorities, then read back
	task automatic test_insert_order;
		send_request(OP_INSERT, 8'h11, 16'sd0);
		send_request(OP_INSERT, 8'hFF, 16'sh7FFF);
		send_request(OP_INSERT, 8'h00, 16'sh8000);
		send_request(OP_INSERT, 8'h22, 16'sd0);
		send_request(OP_INSERT, 8'h33, -16'sd1);
		send_request(OP_INSERT, 8'h44, 16'sd1);
		send_request(OP_INSERT, 8'h55, 16'sd0);
		send_request(OP_DUMP, 8'h00, 16'sd0);
	endtask

	// random inserts and dumps until the table is full, draining once half way
	task automatic test_random_fill;
		bit drained;
		drained = 1'b0;
		while (stored_count < DEPTH) begin
			if (!drained && stored_count == DEPTH / 2) begin
				wait_for_results();
				drained = 1'b1;
			end
			if ($urandom_range(0, 2) != 0)
				send_request(OP_INSERT, 8'($urandom()), pick_priority());
			else
				send_request(OP_DUMP, 8'($urandom()), 16'($urandom()));
		end
	endtask

	// inserts into a full table are dropped, the dump shows all entries unchanged
	task automatic test_full_table;
		send_request(OP_INSERT, 8'hFF, 16'sh7FFF);
		send_request(OP_INSERT, 8'h00, 16'sh8000);
		send_request(OP_DUMP, 8'hFF, 16'shFFFF);
	endtask

	// long random mix on the full table, closing stretch without any idling
	task automatic test_random_full;
		for (int n = 0; n < 300; n++) begin
			if (n == 240)
				steady_phase = 1'b1;
			if ($urandom_range(0, 1) == 0)
				send_request(OP_DUMP, 8'($urandom()), 16'($urandom()));
			else
				send_request(OP_INSERT, 8'($urandom()), pick_priority());
		end
	endtask

	// receiver side: random stall bursts except in the steady phase
	initial begin
		int unsigned hold;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!steady_phase && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 12);
				rsp_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// every accepted result against the oldest owed one, field by field
	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = rsp_ch.payload;
			result_count++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d not expected: status %0d data %0h prio %0d",
					result_count, got.status, got.out_data, got.out_priority));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("result %0d status %0d, expected %0d",
						result_count, got.status, want.status));
				if (got.out_data !== want.out_data)
					report_mismatch($sformatf("result %0d data %0h, expected %0h",
						result_count, got.out_data, want.out_data));
				if (got.out_priority !== want.out_priority)
					report_mismatch($sformatf("result %0d priority %0d, expected %0d",
						result_count, got.out_priority, want.out_priority));
				if (got.occupancy !== want.occupancy)
					report_mismatch($sformatf("result %0d occupancy %0d, expected %0d",
						result_count, got.occupancy, want.occupancy));
				if (got.last !== want.last)
					report_mismatch($sformatf("result %0d last %0b, expected %0b",
						result_count, got.last, want.last));
			end
		end
	end

	// hard stop in case the block hangs
	initial begin
		#RUN_LIMIT_NS;
		$display("** sorted_priority_table_insert: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		stored_count = 0;
		mismatch_count = 0;
		result_count = 0;
		steady_phase = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_dump();
		test_insert_order();
		test_random_fill();
		test_full_table();
		test_random_full();

		// let the last results drain, then wait quietly for anything stray
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		if (mismatch_count == 0) begin
			$display("** sorted_priority_table_insert: PASSED **");
		end else begin
			$display("** sorted_priority_table_insert: FAILED **");
		end
		$finish;
	end

endmodule
